FILE: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

    localparam int BITS_PER_BYTE = 8;

    // Reset values of the timing registers
    localparam logic [7:0] LONG_PHASE_RST  = 8'd4;
    localparam logic [7:0] SHORT_PHASE_RST = 8'd2;
    localparam logic [7:0] ACK_SAMPLE_RST  = 8'd1;

    // One timing tick as seen by the sequencer
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       sda_in;
    } tick_t;

    // One result transaction
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_in;
        logic       rejected;
    } res_t;

    // Timing configuration handed to the sequencer
    typedef struct packed {
        logic [7:0] long_phase_ticks;
        logic [7:0] short_phase_ticks;
        logic [7:0] ack_sample_ticks;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/i2cm_if.sv
// ----------------------------------------------------------------------------
// i2cm_if
// Valid/ready channel interfaces for tick input and result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_tick_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       sda_in;

    modport source (output valid, cmd_valid, req_type, tx_byte, sda_in, input ready);
    modport sink   (input valid, cmd_valid, req_type, tx_byte, sda_in, output ready);
endinterface

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_in;
    logic       rejected;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_in,
                    rejected, input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_in,
                    rejected, output ready);
endinterface

`default_nettype wire

FILE: rtl/i2cm_cfg.sv
// ----------------------------------------------------------------------------
// i2cm_cfg
// APB register file holding the bus phase timing.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_cfg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready,
    output i2cm_pkg::cfg_t      cfg
);
    import i2cm_pkg::*;

    localparam logic [1:0] REG_LONG  = 2'd0;
    localparam logic [1:0] REG_SHORT = 2'd1;
    localparam logic [1:0] REG_ACK   = 2'd2;

    logic [7:0] long_reg;
    logic [7:0] short_reg;
    logic [7:0] ack_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reg  <= LONG_PHASE_RST;
            short_reg <= SHORT_PHASE_RST;
            ack_reg   <= ACK_SAMPLE_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_LONG:  long_reg  <= pwdata[7:0];
                REG_SHORT: short_reg <= pwdata[7:0];
                REG_ACK:   ack_reg   <= pwdata[7:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LONG:  prdata = {24'd0, long_reg};
            REG_SHORT: prdata = {24'd0, short_reg};
            REG_ACK:   prdata = {24'd0, ack_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign cfg.long_phase_ticks  = long_reg;
    assign cfg.short_phase_ticks = short_reg;
    assign cfg.ack_sample_ticks  = ack_reg;

endmodule

`default_nettype wire

FILE: rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus phase sequencer: advances one tick per step and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step_en,
    input  i2cm_pkg::tick_t     tick,
    input  i2cm_pkg::cfg_t      cfg,
    output i2cm_pkg::res_t      res_next
);
    import i2cm_pkg::*;

    localparam logic [2:0] REQ_START   = 3'd0;
    localparam logic [2:0] REQ_STOP    = 3'd1;
    localparam logic [2:0] REQ_WRITE   = 3'd2;
    localparam logic [2:0] REQ_RD_ACK  = 3'd3;
    localparam logic [2:0] REQ_RD_NACK = 3'd4;

    localparam logic [3:0] BIT_LAST = 4'(BITS_PER_BYTE);

    typedef enum logic [15:0] {
        PH_IDLE    = 16'h0001,
        PH_START_A = 16'h0002,
        PH_START_B = 16'h0004,
        PH_STOP_A  = 16'h0008,
        PH_STOP_B  = 16'h0010,
        PH_STOP_C  = 16'h0020,
        PH_W_SETUP = 16'h0040,
        PH_W_HIGH  = 16'h0080,
        PH_W_GAP   = 16'h0100,
        PH_K_SETUP = 16'h0200,
        PH_K_PRE   = 16'h0400,
        PH_K_POST  = 16'h0800,
        PH_R_LOW   = 16'h1000,
        PH_R_HIGH  = 16'h2000,
        PH_A_LOW   = 16'h4000,
        PH_A_HIGH  = 16'h8000
    } phase_t;

    phase_t     phase_reg,   phase_next;
    logic [2:0] cmd_reg,     cmd_next;
    logic [3:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] tick_cnt_reg, tick_cnt_next;
    logic [7:0] shreg_reg,   shreg_next;
    logic       scl_reg,     scl_next;
    logic       sda_reg,     sda_next;
    logic       ack_reg,     ack_next;
    logic [7:0] rx_reg,      rx_next;
    logic       done;
    logic       rej;
    logic [7:0] long_load;
    logic [7:0] short_load;
    logic [3:0] bit_inc;

    // A zero phase length behaves as one tick; load value is length minus one
    assign long_load  = (cfg.long_phase_ticks  == 8'd0) ? 8'd0 : cfg.long_phase_ticks  - 8'd1;
    assign short_load = (cfg.short_phase_ticks == 8'd0) ? 8'd0 : cfg.short_phase_ticks - 8'd1;
    assign bit_inc    = bit_cnt_reg + 4'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        cmd_next      = cmd_reg;
        bit_cnt_next  = bit_cnt_reg;
        tick_cnt_next = tick_cnt_reg;
        shreg_next    = shreg_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        ack_next      = ack_reg;
        rx_next       = rx_reg;
        done          = 1'b0;
        rej           = 1'b0;

        if (phase_reg != PH_IDLE)
        begin
            rej = tick.cmd_valid;
            if (tick_cnt_reg != 8'd0)
            begin
                tick_cnt_next = tick_cnt_reg - 8'd1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START_A:
                    begin
                        sda_next      = 1'b0;
                        phase_next    = PH_START_B;
                        tick_cnt_next = long_load;
                    end
                    PH_START_B:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_STOP_A:
                    begin
                        scl_next      = 1'b1;
                        phase_next    = PH_STOP_B;
                        tick_cnt_next = long_load;
                    end
                    PH_STOP_B:
                    begin
                        sda_next      = 1'b1;
                        phase_next    = PH_STOP_C;
                        tick_cnt_next = long_load;
                    end
                    PH_W_SETUP:
                    begin
                        scl_next      = 1'b1;
                        phase_next    = PH_W_HIGH;
                        tick_cnt_next = long_load;
                    end
                    PH_W_HIGH:
                    begin
                        scl_next      = 1'b0;
                        phase_next    = PH_W_GAP;
                        tick_cnt_next = short_load;
                    end
                    PH_W_GAP:
                    begin
                        bit_cnt_next = bit_inc;
                        if (bit_inc < BIT_LAST)
                        begin
                            sda_next      = shreg_reg[7];
                            shreg_next    = {shreg_reg[6:0], 1'b0};
                            scl_next      = 1'b0;
                            phase_next    = PH_W_SETUP;
                            tick_cnt_next = long_load;
                        end
                        else
                        begin
                            sda_next      = 1'b1;
                            phase_next    = PH_K_SETUP;
                            tick_cnt_next = long_load;
                        end
                    end
                    PH_K_SETUP:
                    begin
                        scl_next = 1'b1;
                        if (cfg.ack_sample_ticks == 8'd0)
                        begin
                            ack_next      = tick.sda_in;
                            phase_next    = PH_K_POST;
                            tick_cnt_next = long_load;
                        end
                        else
                        begin
                            phase_next    = PH_K_PRE;
                            tick_cnt_next = cfg.ack_sample_ticks - 8'd1;
                        end
                    end
                    PH_K_PRE:
                    begin
                        ack_next      = tick.sda_in;
                        phase_next    = PH_K_POST;
                        tick_cnt_next = long_load;
                    end
                    PH_K_POST:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_R_LOW:
                    begin
                        scl_next      = 1'b1;
                        shreg_next    = {shreg_reg[6:0], tick.sda_in};
                        phase_next    = PH_R_HIGH;
                        tick_cnt_next = long_load;
                    end
                    PH_R_HIGH:
                    begin
                        scl_next     = 1'b0;
                        bit_cnt_next = bit_inc;
                        if (bit_inc < BIT_LAST)
                        begin
                            sda_next      = 1'b1;
                            phase_next    = PH_R_LOW;
                            tick_cnt_next = long_load;
                        end
                        else
                        begin
                            rx_next       = shreg_reg;
                            sda_next      = (cmd_reg == REQ_RD_NACK);
                            phase_next    = PH_A_LOW;
                            tick_cnt_next = short_load;
                        end
                    end
                    PH_A_LOW:
                    begin
                        scl_next      = 1'b1;
                        phase_next    = PH_A_HIGH;
                        tick_cnt_next = short_load;
                    end
                    PH_A_HIGH:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    // end of stop, and any code outside the phase set
                    default:
                    begin
                        phase_next    = PH_IDLE;
                        tick_cnt_next = 8'd0;
                        done          = 1'b1;
                    end
                endcase
            end
        end
        else if (tick.cmd_valid)
        begin
            unique case (tick.req_type) inside
                REQ_START:
                begin
                    cmd_next      = tick.req_type;
                    bit_cnt_next  = 4'd0;
                    scl_next      = 1'b1;
                    sda_next      = 1'b1;
                    phase_next    = PH_START_A;
                    tick_cnt_next = long_load;
                end
                REQ_STOP:
                begin
                    cmd_next      = tick.req_type;
                    bit_cnt_next  = 4'd0;
                    scl_next      = 1'b0;
                    sda_next      = 1'b0;
                    phase_next    = PH_STOP_A;
                    tick_cnt_next = long_load;
                end
                REQ_WRITE:
                begin
                    cmd_next      = tick.req_type;
                    bit_cnt_next  = 4'd0;
                    sda_next      = tick.tx_byte[7];
                    shreg_next    = {tick.tx_byte[6:0], 1'b0};
                    scl_next      = 1'b0;
                    phase_next    = PH_W_SETUP;
                    tick_cnt_next = long_load;
                end
                REQ_RD_ACK, REQ_RD_NACK:
                begin
                    cmd_next      = tick.req_type;
                    bit_cnt_next  = 4'd0;
                    shreg_next    = 8'd0;
                    scl_next      = 1'b0;
                    sda_next      = 1'b1;
                    phase_next    = PH_R_LOW;
                    tick_cnt_next = long_load;
                end
                default: rej = 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            cmd_reg      <= 3'd0;
            bit_cnt_reg  <= 4'd0;
            tick_cnt_reg <= 8'd0;
            shreg_reg    <= 8'd0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            ack_reg      <= 1'b0;
            rx_reg       <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            cmd_reg      <= cmd_next;
            bit_cnt_reg  <= bit_cnt_next;
            tick_cnt_reg <= tick_cnt_next;
            shreg_reg    <= shreg_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            ack_reg      <= ack_next;
            rx_reg       <= rx_next;
        end
    end

    assign res_next.scl_out  = scl_next;
    assign res_next.sda_out  = sda_next;
    assign res_next.busy_res = (phase_next != PH_IDLE);
    assign res_next.done_res = done;
    assign res_next.rx_byte  = rx_next;
    assign res_next.ack_in   = ack_next;
    assign res_next.rejected = rej;

endmodule

`default_nettype wire

FILE: rtl/i2c_master_byte_engine.sv
// Path: an accepted tick transaction goes through the input register, then the
//   sequencer step, into the result register, from which it can leave.
// Throughput: one tick per clock; a tick is taken while a result waits,
//   as long as the input register is free or the result register drains.
// Reset (rst_n, async, low): pipeline empty, bus lines released, sequencer
//   idle, timing registers back to 4 / 2 / 1 ticks.
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Byte-level I2C master: start, stop, write and read byte, one tick per step.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    i2cm_tick_if.sink           cmd,
    i2cm_res_if.source          result,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready
);
    import i2cm_pkg::*;

    cfg_t  cfg;
    tick_t tick_in;
    tick_t tick_reg;
    res_t  res_next;
    res_t  res_reg;
    logic  in_vld_reg;
    logic  out_vld_reg;
    logic  adv;       // pipeline moves: result register is free or draining
    logic  step_en;   // sequencer consumes the held tick this cycle

    // Timing registers
    i2cm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Flow control: the result register parts the two sides, so the input
    // stage still takes a tick into an empty input register while a result is unread.
    assign adv       = !out_vld_reg || result.ready;
    assign step_en   = adv && in_vld_reg;
    assign cmd.ready = !in_vld_reg || adv;

    assign tick_in.cmd_valid = cmd.cmd_valid;
    assign tick_in.req_type  = cmd.req_type;
    assign tick_in.tx_byte   = cmd.tx_byte;
    assign tick_in.sda_in    = cmd.sda_in;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_vld_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            tick_reg <= tick_in;
        end
    end

    // Sequencer: state advances only when the held tick moves into the
    // result register, so stalls never skip or repeat a tick.
    i2cm_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (step_en),
        .tick     (tick_reg),
        .cfg      (cfg),
        .res_next (res_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid    = out_vld_reg;
    assign result.scl_out  = res_reg.scl_out;
    assign result.sda_out  = res_reg.sda_out;
    assign result.busy_res = res_reg.busy_res;
    assign result.done_res = res_reg.done_res;
    assign result.rx_byte  = res_reg.rx_byte;
    assign result.ack_in   = res_reg.ack_in;
    assign result.rejected = res_reg.rejected;

endmodule

`default_nettype wire

FILE: rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the engine's channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_ready,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic       scl_out,
    input  wire logic       sda_out,
    input  wire logic       busy_res,
    input  wire logic       done_res,
    input  wire logic [7:0] rx_byte,
    input  wire logic       ack_in,
    input  wire logic       rejected
);
    logic [13:0] payload;

    assign payload = {scl_out, sda_out, busy_res, done_res, rx_byte, ack_in, rejected};

    // A completing transaction leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done_res with busy_res set");

    // With no pending result the input side must be open
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while result register is empty");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(payload))
        else $error("result payload changed while stalled");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (cmd.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .scl_out   (result.scl_out),
    .sda_out   (result.sda_out),
    .busy_res  (result.busy_res),
    .done_res  (result.done_res),
    .rx_byte   (result.rx_byte),
    .ack_in    (result.ack_in),
    .rejected  (result.rejected)
);

`default_nettype wire

FILE: sim/i2c_master_byte_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_tb
// Self-checking bench for the byte-level I2C master. Every accepted tick is
// run through a cycle-exact model of the bus sequencer, and each result
// transaction is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module i2c_master_byte_engine_tb;

    import i2cm_pkg::*;

    // Register map: one 32-bit word per timing register
    localparam int REG_LONG_PHASE  = 0;
    localparam int REG_SHORT_PHASE = 1;
    localparam int REG_ACK_SAMPLE  = 2;

    // Directed rows: fill count meaning "keep ticking until the command ends"
    localparam int FILL_TO_IDLE = -1;

    // Minimum ticks each random timing setting runs for before the next one
    localparam int unsigned PHASE_ITEMS = 40;

    // Generous wall for the whole run, in nanoseconds
    localparam longint RUN_LIMIT_NS = 64'd40_000_000;

    typedef enum logic [2:0] {
        REQ_START     = 3'd0,
        REQ_STOP      = 3'd1,
        REQ_WRITE     = 3'd2,
        REQ_READ_ACK  = 3'd3,
        REQ_READ_NACK = 3'd4,
        REQ_RSVD5     = 3'd5,
        REQ_RSVD6     = 3'd6,
        REQ_RSVD7     = 3'd7
    } req_e;

    // Bus sequencer phases, mirroring the phases of i2cm_seq
    typedef enum logic [3:0] {
        ST_IDLE, ST_START_SETUP, ST_START_HOLD,
        ST_STOP_LOW, ST_STOP_SCL, ST_STOP_SDA,
        ST_WR_BIT, ST_WR_HIGH, ST_WR_GAP,
        ST_ACK_SETUP, ST_ACK_WAIT, ST_ACK_HOLD,
        ST_RD_LOW, ST_RD_HIGH, ST_ANS_LOW, ST_ANS_HIGH
    } seq_phase_e;

    typedef enum logic { ROW_TICK, ROW_CFG } row_kind_e;

    typedef struct {
        row_kind_e  kind;
        tick_t      tk;
        int         fill;       // quiet ticks after tk, or FILL_TO_IDLE
        logic       fill_sda;
        bit         typed;      // want holds a hand-written expectation
        res_t       want;
        int         reg_idx;
        logic [7:0] reg_val;
    } dir_row_t;

    // Bus released, nothing ever received: the look of a freshly reset engine
    localparam res_t RES_AT_REST = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
                                     done_res: 1'b0, rx_byte: 8'h00, ack_in: 1'b0,
                                     rejected: 1'b0};
    localparam res_t RES_REJECT_AT_REST = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
                                            done_res: 1'b0, rx_byte: 8'h00, ack_in: 1'b0,
                                            rejected: 1'b1};

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    i2cm_tick_if tick_if ();
    i2cm_res_if  res_if ();

    i2c_master_byte_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (tick_if),
        .result  (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Sequencer model state (reset values)
    // ------------------------------------------------------------------
    cfg_t       timing    = '{LONG_PHASE_RST, SHORT_PHASE_RST, ACK_SAMPLE_RST};
    seq_phase_e seq_ph    = ST_IDLE;
    logic [2:0] seq_cmd   = 3'd0;
    logic [3:0] seq_bits  = 4'd0;
    logic [7:0] seq_wait  = 8'd0;
    logic [7:0] seq_shift = 8'd0;
    logic [7:0] rx_last   = 8'd0;
    logic       scl_drv   = 1'b1;
    logic       sda_drv   = 1'b1;
    logic       slave_ack = 1'b0;
    logic       seq_done;

    res_t        bus_state_q[$];    // predicted line levels and flags, oldest first
    int unsigned mismatches  = 0;
    int unsigned items_sent  = 0;
    bit          steady      = 1'b0; // no gaps on either side while set

    // A zero phase length still lasts one tick
    function automatic logic [7:0] long_len();
        return (timing.long_phase_ticks == 8'd0) ? 8'd1 : timing.long_phase_ticks;
    endfunction

    function automatic logic [7:0] short_len();
        return (timing.short_phase_ticks == 8'd0) ? 8'd1 : timing.short_phase_ticks;
    endfunction

    // The entry tick counts as the first tick of the phase
    function automatic void enter_phase(seq_phase_e ph, logic [7:0] dur);
        seq_ph   = ph;
        seq_wait = dur - 8'd1;
    endfunction

    function automatic void finish_cmd();
        seq_ph   = ST_IDLE;
        seq_wait = 8'd0;
        seq_done = 1'b1;
    endfunction

    // MSB onto SDA with SCL low
    function automatic void drive_next_bit();
        sda_drv   = seq_shift[7];
        seq_shift = {seq_shift[6:0], 1'b0};
        scl_drv   = 1'b0;
        enter_phase(ST_WR_BIT, long_len());
    endfunction

    // One tick through the sequencer; r is what the engine shows afterwards
    task automatic bus_step(input tick_t t, output res_t r);
        logic rej;
        rej      = 1'b0;
        seq_done = 1'b0;
        if (seq_ph != ST_IDLE)
        begin
            // Busy: any offered command is dropped and flagged
            rej = t.cmd_valid;
            if (seq_wait != 8'd0)
            begin
                seq_wait = seq_wait - 8'd1;
            end
            else
            begin
                case (seq_ph)
                    ST_START_SETUP: begin sda_drv = 1'b0; enter_phase(ST_START_HOLD, long_len()); end
                    ST_START_HOLD:  begin scl_drv = 1'b0; finish_cmd(); end
                    ST_STOP_LOW:    begin scl_drv = 1'b1; enter_phase(ST_STOP_SCL, long_len()); end
                    ST_STOP_SCL:    begin sda_drv = 1'b1; enter_phase(ST_STOP_SDA, long_len()); end
                    ST_STOP_SDA:    finish_cmd();
                    ST_WR_BIT:      begin scl_drv = 1'b1; enter_phase(ST_WR_HIGH, long_len()); end
                    ST_WR_HIGH:     begin scl_drv = 1'b0; enter_phase(ST_WR_GAP, short_len()); end
                    ST_WR_GAP:
                    begin
                        seq_bits = seq_bits + 4'd1;
                        if (seq_bits < BITS_PER_BYTE)
                        begin
                            drive_next_bit();
                        end
                        else
                        begin
                            // Release SDA for the slave answer
                            sda_drv = 1'b1;
                            enter_phase(ST_ACK_SETUP, long_len());
                        end
                    end
                    ST_ACK_SETUP:
                    begin
                        scl_drv = 1'b1;
                        if (timing.ack_sample_ticks == 8'd0)
                        begin
                            // No sample delay: take ACK on the rising tick
                            slave_ack = t.sda_in;
                            enter_phase(ST_ACK_HOLD, long_len());
                        end
                        else
                        begin
                            enter_phase(ST_ACK_WAIT, timing.ack_sample_ticks);
                        end
                    end
                    ST_ACK_WAIT:    begin slave_ack = t.sda_in; enter_phase(ST_ACK_HOLD, long_len()); end
                    ST_ACK_HOLD:    begin scl_drv = 1'b0; finish_cmd(); end
                    ST_RD_LOW:
                    begin
                        // Data bit captured as SCL goes high
                        scl_drv   = 1'b1;
                        seq_shift = {seq_shift[6:0], t.sda_in};
                        enter_phase(ST_RD_HIGH, long_len());
                    end
                    ST_RD_HIGH:
                    begin
                        scl_drv  = 1'b0;
                        seq_bits = seq_bits + 4'd1;
                        if (seq_bits < BITS_PER_BYTE)
                        begin
                            sda_drv = 1'b1;
                            enter_phase(ST_RD_LOW, long_len());
                        end
                        else
                        begin
                            rx_last = seq_shift;
                            sda_drv = (seq_cmd == REQ_READ_NACK);
                            enter_phase(ST_ANS_LOW, short_len());
                        end
                    end
                    ST_ANS_LOW:     begin scl_drv = 1'b1; enter_phase(ST_ANS_HIGH, short_len()); end
                    ST_ANS_HIGH:    begin scl_drv = 1'b0; finish_cmd(); end
                    default:        finish_cmd();
                endcase
            end
        end
        else if (t.cmd_valid)
        begin
            if (t.req_type > REQ_READ_NACK)
            begin
                rej = 1'b1;
            end
            else
            begin
                seq_cmd  = t.req_type;
                seq_bits = 4'd0;
                case (t.req_type)
                    REQ_START:
                    begin
                        scl_drv = 1'b1;
                        sda_drv = 1'b1;
                        enter_phase(ST_START_SETUP, long_len());
                    end
                    REQ_STOP:
                    begin
                        scl_drv = 1'b0;
                        sda_drv = 1'b0;
                        enter_phase(ST_STOP_LOW, long_len());
                    end
                    REQ_WRITE:
                    begin
                        seq_shift = t.tx_byte;
                        drive_next_bit();
                    end
                    default:
                    begin
                        seq_shift = 8'd0;
                        scl_drv   = 1'b0;
                        sda_drv   = 1'b1;
                        enter_phase(ST_RD_LOW, long_len());
                    end
                endcase
            end
        end
        r.scl_out  = scl_drv;
        r.sda_out  = sda_drv;
        r.busy_res = (seq_ph != ST_IDLE);
        r.done_res = seq_done;
        r.rx_byte  = rx_last;
        r.ack_in   = slave_ack;
        r.rejected = rej;
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting and field compare
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic bit take_gap();
        return !steady && ($urandom_range(0, 99) < 15);
    endfunction

    // No command on this tick; unused fields still toggle
    function automatic tick_t quiet_tick(input logic sda);
        tick_t t;
        t.cmd_valid = 1'b0;
        t.req_type  = 3'($urandom);
        t.tx_byte   = 8'($urandom);
        t.sda_in    = sda;
        return t;
    endfunction

    function automatic dir_row_t tick_row(input logic cv, input logic [2:0] req,
                                          input logic [7:0] txb, input logic sda,
                                          input int fill, input logic fill_sda,
                                          input bit typed = 1'b0, input res_t want = '0);
        dir_row_t row;
        row.kind     = ROW_TICK;
        row.tk       = '{cmd_valid: cv, req_type: req, tx_byte: txb, sda_in: sda};
        row.fill     = fill;
        row.fill_sda = fill_sda;
        row.typed    = typed;
        row.want     = want;
        row.reg_idx  = 0;
        row.reg_val  = 8'd0;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input int idx, input logic [7:0] val);
        dir_row_t row;
        row          = tick_row(1'b0, REQ_START, 8'h00, 1'b0, 0, 1'b0);
        row.kind     = ROW_CFG;
        row.reg_idx  = idx;
        row.reg_val  = val;
        return row;
    endfunction

    // Offer one tick transaction; predict when it is taken. Valid is left high
    // on return so the next call never toggles it within one time step.
    task automatic send_tick(input tick_t t, input bit typed = 1'b0, input res_t want = '0);
        res_t r;
        while (take_gap())
        begin
            tick_if.valid <= 1'b0;
            @(posedge clk);
        end
        tick_if.valid     <= 1'b1;
        tick_if.cmd_valid <= t.cmd_valid;
        tick_if.req_type  <= t.req_type;
        tick_if.tx_byte   <= t.tx_byte;
        tick_if.sda_in    <= t.sda_in;
        do @(posedge clk); while (!tick_if.ready);
        bus_step(t, r);
        bus_state_q.push_back(typed ? want : r);
        items_sent++;
    endtask

    // Issue a command from idle and tick it through to the end. A few percent
    // of the busy ticks carry a stray command, which must be rejected.
    task automatic run_command(input logic [2:0] req, input logic [7:0] txb);
        tick_t t;
        t = '{cmd_valid: 1'b1, req_type: req, tx_byte: txb, sda_in: 1'($urandom)};
        send_tick(t);
        while (seq_ph != ST_IDLE)
        begin
            t = quiet_tick(1'($urandom));
            t.cmd_valid = ($urandom_range(0, 99) < 3);
            send_tick(t);
        end
        repeat ($urandom_range(0, 2)) send_tick(quiet_tick(1'($urandom)));
    endtask

    // Bring the sequencer to idle, lower valid and drain all results, then
    // allow the pipeline latency before touching the registers.
    task automatic settle_bus();
        while (seq_ph != ST_IDLE)
            send_tick(quiet_tick(1'($urandom)));
        tick_if.valid <= 1'b0;
        while (bus_state_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write; psel/penable stay up on return so back-to-back writes
    // do not drop and raise them in one step. Caller releases the bus.
    task automatic write_reg(input int idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(4 * idx);
        pwdata  <= {24'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_LONG_PHASE:  timing.long_phase_ticks  = val;
            REG_SHORT_PHASE: timing.short_phase_ticks = val;
            REG_ACK_SAMPLE:  timing.ack_sample_ticks  = val;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("i2c_master_byte_engine_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random backpressure, compare against oldest prediction
    // ------------------------------------------------------------------
    initial
    begin
        res_t want;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
            begin
                if (bus_state_q.size() == 0)
                begin
                    flag_mismatch("result transaction with no prediction pending");
                end
                else
                begin
                    want = bus_state_q.pop_front();
                    check_field("scl_out",  res_if.scl_out,  want.scl_out);
                    check_field("sda_out",  res_if.sda_out,  want.sda_out);
                    check_field("busy_res", res_if.busy_res, want.busy_res);
                    check_field("done_res", res_if.done_res, want.done_res);
                    check_field("rx_byte",  res_if.rx_byte,  want.rx_byte);
                    check_field("ack_in",   res_if.ack_in,   want.ack_in);
                    check_field("rejected", res_if.rejected, want.rejected);
                end
            end
            res_if.ready <= !take_gap();
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        dir_row_t    plan[$];
        cfg_t        phase_cfg[6];
        int unsigned target;
        int unsigned n_ops;

        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= 4'd0;
        pwdata            <= 32'd0;
        tick_if.valid     <= 1'b0;
        tick_if.cmd_valid <= 1'b0;
        tick_if.req_type  <= REQ_START;
        tick_if.tx_byte   <= 8'h00;
        tick_if.sda_in    <= 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset look and unknown codes are typed in; the rest is
        // checked by the model. Timing starts at the reset values 4/2/1.
        plan.push_back(tick_row(1'b0, REQ_START, 8'h00, 1'b0, 0, 1'b0, 1'b1, RES_AT_REST));
        plan.push_back(tick_row(1'b0, REQ_RSVD7, 8'hFF, 1'b1, 0, 1'b0, 1'b1, RES_AT_REST));
        plan.push_back(tick_row(1'b1, REQ_RSVD7, 8'h00, 1'b0, 0, 1'b0, 1'b1, RES_REJECT_AT_REST));
        plan.push_back(tick_row(1'b1, REQ_RSVD5, 8'hFF, 1'b1, 0, 1'b0, 1'b1, RES_REJECT_AT_REST));
        plan.push_back(tick_row(1'b1, REQ_RSVD6, 8'h00, 1'b0, 0, 1'b0, 1'b1, RES_REJECT_AT_REST));
        // Start lasts 9 ticks at 4/2/1: next row lands on its completing tick
        plan.push_back(tick_row(1'b1, REQ_START, 8'h00, 1'b1, 7, 1'b1));
        plan.push_back(tick_row(1'b1, REQ_WRITE, 8'hFF, 1'b0, 0, 1'b0));
        // Write, then a read offered mid-byte (rejected); slave ACKs
        plan.push_back(tick_row(1'b1, REQ_WRITE, 8'hA5, 1'b0, 3, 1'b0));
        plan.push_back(tick_row(1'b1, REQ_READ_ACK, 8'h00, 1'b0, FILL_TO_IDLE, 1'b0));
        // Slave NACKs
        plan.push_back(tick_row(1'b1, REQ_WRITE, 8'h5A, 1'b1, FILL_TO_IDLE, 1'b1));
        plan.push_back(tick_row(1'b1, REQ_READ_ACK, 8'h00, 1'b1, FILL_TO_IDLE, 1'b1));
        plan.push_back(tick_row(1'b1, REQ_READ_NACK, 8'hFF, 1'b0, FILL_TO_IDLE, 1'b0));
        plan.push_back(tick_row(1'b1, REQ_WRITE, 8'h00, 1'b0, FILL_TO_IDLE, 1'b0));
        plan.push_back(tick_row(1'b1, REQ_STOP, 8'h00, 1'b1, FILL_TO_IDLE, 1'b1));
        // All timing zero: one-tick phases, ACK taken on the rising tick
        plan.push_back(cfg_row(REG_LONG_PHASE, 8'd0));
        plan.push_back(cfg_row(REG_SHORT_PHASE, 8'd0));
        plan.push_back(cfg_row(REG_ACK_SAMPLE, 8'd0));
        plan.push_back(tick_row(1'b1, REQ_START, 8'h00, 1'b0, 1, 1'b0));
        plan.push_back(tick_row(1'b1, REQ_STOP, 8'h00, 1'b0, 0, 1'b0));
        plan.push_back(tick_row(1'b1, REQ_WRITE, 8'hFF, 1'b0, FILL_TO_IDLE, 1'b0));
        plan.push_back(tick_row(1'b1, REQ_READ_NACK, 8'h00, 1'b1, FILL_TO_IDLE, 1'b1));
        plan.push_back(tick_row(1'b1, REQ_STOP, 8'hFF, 1'b0, FILL_TO_IDLE, 1'b0));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle_bus();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
                psel    <= 1'b0;
                penable <= 1'b0;
            end
            else
            begin
                send_tick(plan[i].tk, plan[i].typed, plan[i].want);
                if (plan[i].fill == FILL_TO_IDLE)
                begin
                    while (seq_ph != ST_IDLE)
                        send_tick(quiet_tick(plan[i].fill_sda));
                end
                else
                begin
                    repeat (plan[i].fill) send_tick(quiet_tick(plan[i].fill_sda));
                end
            end
        end

        // Random: one timing setting per phase, each run for a fixed share
        // of ticks; zero lengths included, the last setting drawn at random.
        phase_cfg[0] = '{8'd1, 8'd1, 8'd0};
        phase_cfg[1] = '{8'd0, 8'd0, 8'd0};
        phase_cfg[2] = '{8'd2, 8'd1, 8'd2};
        phase_cfg[3] = '{8'd3, 8'd1, 8'd9};
        phase_cfg[4] = '{LONG_PHASE_RST, SHORT_PHASE_RST, ACK_SAMPLE_RST};
        phase_cfg[5] = '{8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                         8'($urandom_range(0, 8))};

        for (int p = 0; p < 6; p++)
        begin
            settle_bus();
            write_reg(REG_LONG_PHASE,  phase_cfg[p].long_phase_ticks);
            write_reg(REG_SHORT_PHASE, phase_cfg[p].short_phase_ticks);
            write_reg(REG_ACK_SAMPLE,  phase_cfg[p].ack_sample_ticks);
            psel    <= 1'b0;
            penable <= 1'b0;
            // First phase runs with no gaps or stalls at all
            steady = (p == 0);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    // Well-formed bus transaction: start, address, at most one data operation, stop
                    run_command(REQ_START, 8'($urandom));
                    run_command(REQ_WRITE, 8'($urandom));
                    n_ops = $urandom_range(0, 1);
                    repeat (n_ops)
                    begin
                        case ($urandom_range(0, 2))
                            0:       run_command(REQ_WRITE, 8'($urandom));
                            1:       run_command(REQ_READ_ACK, 8'($urandom));
                            default: run_command(REQ_READ_NACK, 8'($urandom));
                        endcase
                    end
                    run_command(REQ_STOP, 8'($urandom));
                end
                else
                begin
                    // Noise: any code, reserved ones included, out of context
                    run_command(3'($urandom_range(0, 7)), 8'($urandom));
                end
            end
            steady = 1'b0;
        end

        settle_bus();
        if (mismatches == 0)
            $display("i2c_master_byte_engine_tb passed");
        else
            $display("i2c_master_byte_engine_tb failed");
        $finish;
    end

endmodule

FILE: i2c_master_byte_engine.f
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2cm_cfg.sv
rtl/i2cm_seq.sv
rtl/i2c_master_byte_engine.sv
rtl/i2cm_checker.sv
sim/i2c_master_byte_engine_tb.sv
